### rtl/core/http_request_header_parser_unit_defines.svh
// Assertion macros shared by the HTTP request parser checker.
`ifndef HTTP_REQUEST_HEADER_PARSER_UNIT_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HRHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hrhp_pkg.sv
// Types, codes and character helpers for the HTTP request parser.
`timescale 1ns / 1ps
package hrhp_pkg;

    typedef enum logic [23:0] {
        PH_METHOD_START = 24'h000001,
        PH_METHOD       = 24'h000002,
        PH_URI_START    = 24'h000004,
        PH_URI          = 24'h000008,
        PH_H            = 24'h000010,
        PH_T1           = 24'h000020,
        PH_T2           = 24'h000040,
        PH_P            = 24'h000080,
        PH_SLASH        = 24'h000100,
        PH_MAJ_START    = 24'h000200,
        PH_MAJ          = 24'h000400,
        PH_MIN_START    = 24'h000800,
        PH_MIN          = 24'h001000,
        PH_NL1          = 24'h002000,
        PH_LINE_START   = 24'h004000,
        PH_LWS          = 24'h008000,
        PH_NAME         = 24'h010000,
        PH_SP_VALUE     = 24'h020000,
        PH_VALUE        = 24'h040000,
        PH_NL2          = 24'h080000,
        PH_NL3          = 24'h100000,
        PH_BODY         = 24'h200000,
        PH_DONE         = 24'h400000,
        PH_FAIL         = 24'h800000
    } t_phase;

    localparam logic [1:0] VERDICT_MORE      = 2'd0;
    localparam logic [1:0] VERDICT_COMPLETE  = 2'd1;
    localparam logic [1:0] VERDICT_MALFORMED = 2'd2;

    localparam logic [2:0] CLASS_DELIM  = 3'd0;
    localparam logic [2:0] CLASS_METHOD = 3'd1;
    localparam logic [2:0] CLASS_URI    = 3'd2;
    localparam logic [2:0] CLASS_HNAME  = 3'd3;
    localparam logic [2:0] CLASS_HVALUE = 3'd4;
    localparam logic [2:0] CLASS_BODY   = 3'd5;

    // Progress through "POST": 0 to 4 characters matched, then a miss code.
    localparam logic [2:0] PM_FULL = 3'd4;
    localparam logic [2:0] PM_MISS = 3'd5;

    // Progress through "CONTENT-LENGTH" and its value.
    localparam logic [4:0] NM_FULL   = 5'd14;
    localparam logic [4:0] NM_MISS   = 5'd15;
    localparam logic [4:0] NM_DIGITS = 5'd16;
    localparam logic [4:0] NM_FROZEN = 5'd17;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_CTRL_LAST = 8'd31;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] major;
        logic [7:0] minor;
        logic [2:0] post_prog;
        logic       header_open;
        logic [4:0] name_prog;
    } t_ctl;

    localparam t_ctl CTL_RESET = '{
        phase:       PH_METHOD_START,
        major:       8'd0,
        minor:       8'd0,
        post_prog:   3'd0,
        header_open: 1'b0,
        name_prog:   5'd0
    };

    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] byte_class;
        logic       header_end;
        logic       is_post;
    } t_res;

    function automatic logic is_control(input logic [7:0] c);
        return (c <= CH_CTRL_LAST) || (c == CH_DEL);
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        logic r;
        case (c)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: begin
                r = 1'b1;
            end
            default: begin
                r = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_control(c) && !is_special(c);
    endfunction

    function automatic logic [7:0] post_char(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h50;
            2'd1:    r = 8'h4F;
            2'd2:    r = 8'h53;
            default: r = 8'h54;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cl_char(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h43;
            4'd1:    r = 8'h4F;
            4'd2:    r = 8'h4E;
            4'd3:    r = 8'h54;
            4'd4:    r = 8'h45;
            4'd5:    r = 8'h4E;
            4'd6:    r = 8'h54;
            4'd7:    r = 8'h2D;
            4'd8:    r = 8'h4C;
            4'd9:    r = 8'h45;
            4'd10:   r = 8'h4E;
            4'd11:   r = 8'h47;
            4'd12:   r = 8'h54;
            4'd13:   r = 8'h48;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] post_step(input logic [2:0] prog, input logic [7:0] c);
        logic [2:0] r;
        if ((prog < PM_FULL) && (c == post_char(prog[1:0]))) begin
            r = prog + 3'd1;
        end else begin
            r = PM_MISS;
        end
        return r;
    endfunction

    function automatic logic [4:0] name_step(input logic [4:0] prog, input logic [7:0] c);
        logic [7:0] u;
        logic [4:0] r;
        u = ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
        if ((prog < NM_FULL) && (u == cl_char(prog[3:0]))) begin
            r = prog + 5'd1;
        end else begin
            r = NM_MISS;
        end
        return r;
    endfunction

    // Decimal accumulate with saturation at 255.
    function automatic logic [7:0] acc_dec8(input logic [7:0] v, input logic [7:0] c);
        logic [11:0] t;
        t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {8'd0, c[3:0]};
        return (t > 12'd255) ? 8'hFF : t[7:0];
    endfunction

endpackage

### rtl/core/hrhp_step.sv
// Next-state and result logic for one request byte.
`timescale 1ns / 1ps
module hrhp_step
    import hrhp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  t_ctl                   i_ctl,
    input  logic [LENGTH_BITS-1:0] i_len_cand,
    input  logic [LENGTH_BITS-1:0] i_exp_body,
    input  logic [LENGTH_BITS-1:0] i_body_seen,
    input  logic [7:0]             i_byte,
    input  logic                   i_new_request,
    output t_ctl                   o_ctl,
    output logic [LENGTH_BITS-1:0] o_len_cand,
    output logic [LENGTH_BITS-1:0] o_exp_body,
    output logic [LENGTH_BITS-1:0] o_body_seen,
    output t_res                   o_res,
    output logic [31:0]            o_body_length
);

    localparam int AccW = LENGTH_BITS + 4;
    localparam logic [LENGTH_BITS-1:0] LenMax = '1;

    t_ctl                   cur;
    logic [LENGTH_BITS-1:0] cur_len;
    logic [LENGTH_BITS-1:0] cur_exp;
    logic [LENGTH_BITS-1:0] cur_seen;
    logic [LENGTH_BITS-1:0] acc_in;
    logic [AccW-1:0]        acc_sum;
    logic [LENGTH_BITS-1:0] acc_out;
    logic [4:0]             vc_nm;
    logic [LENGTH_BITS-1:0] vc_len;
    logic [LENGTH_BITS-1:0] commit_exp;
    logic [LENGTH_BITS-1:0] seen_inc;
    logic                   bad;
    t_ctl                   nxt;
    logic [LENGTH_BITS-1:0] nxt_len;
    logic [LENGTH_BITS-1:0] nxt_exp;
    logic [LENGTH_BITS-1:0] nxt_seen;
    logic [1:0]             verdict;
    logic [2:0]             cls;
    logic                   hend;

    // A new request restarts from the reset state before the byte is used.
    assign cur      = i_new_request ? CTL_RESET : i_ctl;
    assign cur_len  = i_new_request ? '0 : i_len_cand;
    assign cur_exp  = i_new_request ? '0 : i_exp_body;
    assign cur_seen = i_new_request ? '0 : i_body_seen;

    // Content length accumulator: the first digit starts from zero.
    assign acc_in  = (cur.name_prog == NM_FULL) ? '0 : cur_len;
    assign acc_sum = (AccW'(acc_in) << 3) + (AccW'(acc_in) << 1) + AccW'(i_byte[3:0]);
    assign acc_out = (acc_sum > AccW'(LenMax)) ? LenMax : acc_sum[LENGTH_BITS-1:0];

    // Effect of a header value character on the length tracking.
    always_comb begin
        vc_nm  = cur.name_prog;
        vc_len = cur_len;
        if (cur.name_prog == NM_FULL) begin
            if (is_dec_digit(i_byte)) begin
                vc_len = acc_out;
                vc_nm  = NM_DIGITS;
            end else if (!is_blank(i_byte)) begin
                vc_nm = NM_FROZEN;
            end
        end else if (cur.name_prog == NM_DIGITS) begin
            if (is_dec_digit(i_byte)) begin
                vc_len = acc_out;
            end else begin
                vc_nm = NM_FROZEN;
            end
        end
    end

    assign commit_exp = ((cur.name_prog == NM_FULL) || (cur.name_prog == NM_DIGITS) ||
                         (cur.name_prog == NM_FROZEN)) ? cur_len : cur_exp;
    assign seen_inc   = cur_seen + LENGTH_BITS'(1);

    always_comb begin
        nxt      = cur;
        nxt_len  = cur_len;
        nxt_exp  = cur_exp;
        nxt_seen = cur_seen;
        verdict  = VERDICT_MORE;
        cls      = CLASS_DELIM;
        hend     = 1'b0;
        bad      = 1'b0;
        case (cur.phase)
            PH_METHOD_START: begin
                if (!is_token(i_byte)) begin
                    bad = 1'b1;
                end else begin
                    nxt.post_prog = post_step(cur.post_prog, i_byte);
                    cls           = CLASS_METHOD;
                    nxt.phase     = PH_METHOD;
                end
            end
            PH_METHOD: begin
                if (i_byte == CH_SPACE) begin
                    nxt.phase = PH_URI_START;
                end else if (!is_token(i_byte)) begin
                    bad = 1'b1;
                end else begin
                    nxt.post_prog = post_step(cur.post_prog, i_byte);
                    cls           = CLASS_METHOD;
                end
            end
            PH_URI_START: begin
                if (is_control(i_byte)) begin
                    bad = 1'b1;
                end else begin
                    cls       = CLASS_URI;
                    nxt.phase = PH_URI;
                end
            end
            PH_URI: begin
                if (i_byte == CH_SPACE) begin
                    nxt.phase = PH_H;
                end else if (is_control(i_byte)) begin
                    bad = 1'b1;
                end else begin
                    cls = CLASS_URI;
                end
            end
            PH_H: begin
                if (i_byte == CH_H) nxt.phase = PH_T1;
                else bad = 1'b1;
            end
            PH_T1: begin
                if (i_byte == CH_T) nxt.phase = PH_T2;
                else bad = 1'b1;
            end
            PH_T2: begin
                if (i_byte == CH_T) nxt.phase = PH_P;
                else bad = 1'b1;
            end
            PH_P: begin
                if (i_byte == CH_P) nxt.phase = PH_SLASH;
                else bad = 1'b1;
            end
            PH_SLASH: begin
                if (i_byte == CH_SLASH) begin
                    nxt.major = 8'd0;
                    nxt.minor = 8'd0;
                    nxt.phase = PH_MAJ_START;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_MAJ_START, PH_MAJ: begin
                if ((cur.phase == PH_MAJ) && (i_byte == CH_DOT)) begin
                    nxt.phase = PH_MIN_START;
                end else if (is_dec_digit(i_byte)) begin
                    nxt.major = acc_dec8(cur.major, i_byte);
                    nxt.phase = PH_MAJ;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_MIN_START, PH_MIN: begin
                if ((cur.phase == PH_MIN) && (i_byte == CH_CR)) begin
                    nxt.phase = PH_NL1;
                end else if (is_dec_digit(i_byte)) begin
                    nxt.minor = acc_dec8(cur.minor, i_byte);
                    nxt.phase = PH_MIN;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_NL1, PH_NL2: begin
                if (i_byte == CH_LF) nxt.phase = PH_LINE_START;
                else bad = 1'b1;
            end
            PH_LINE_START: begin
                if (i_byte == CH_CR) begin
                    nxt.phase = PH_NL3;
                end else if (cur.header_open && is_blank(i_byte)) begin
                    nxt.phase = PH_LWS;
                end else if (!is_token(i_byte)) begin
                    bad = 1'b1;
                end else begin
                    if (cur.header_open) begin
                        nxt_exp = commit_exp;
                        hend    = 1'b1;
                    end
                    nxt.header_open = 1'b1;
                    nxt.name_prog   = name_step(5'd0, i_byte);
                    nxt_len         = '0;
                    cls             = CLASS_HNAME;
                    nxt.phase       = PH_NAME;
                end
            end
            PH_LWS: begin
                if (i_byte == CH_CR) begin
                    nxt.phase = PH_NL2;
                end else if (is_blank(i_byte)) begin
                    nxt.phase = PH_LWS;
                end else if (is_control(i_byte)) begin
                    bad = 1'b1;
                end else begin
                    nxt.name_prog = vc_nm;
                    nxt_len       = vc_len;
                    cls           = CLASS_HVALUE;
                    nxt.phase     = PH_VALUE;
                end
            end
            PH_NAME: begin
                if (i_byte == CH_COLON) begin
                    if (cur.name_prog != NM_FULL) nxt.name_prog = NM_MISS;
                    nxt.phase = PH_SP_VALUE;
                end else if (!is_token(i_byte)) begin
                    bad = 1'b1;
                end else begin
                    nxt.name_prog = name_step(cur.name_prog, i_byte);
                    cls           = CLASS_HNAME;
                end
            end
            PH_SP_VALUE: begin
                if (i_byte == CH_SPACE) begin
                    nxt.phase = PH_VALUE;
                end else if (i_byte == CH_CR) begin
                    nxt.phase = PH_NL2;
                end else if (is_control(i_byte)) begin
                    bad = 1'b1;
                end else begin
                    nxt.name_prog = vc_nm;
                    nxt_len       = vc_len;
                    cls           = CLASS_HVALUE;
                    nxt.phase     = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (i_byte == CH_CR) begin
                    nxt.phase = PH_NL2;
                end else if (is_control(i_byte)) begin
                    bad = 1'b1;
                end else begin
                    nxt.name_prog = vc_nm;
                    nxt_len       = vc_len;
                    cls           = CLASS_HVALUE;
                end
            end
            PH_NL3: begin
                if (i_byte == CH_LF) begin
                    hend            = cur.header_open;
                    nxt.header_open = 1'b0;
                    nxt_seen        = '0;
                    // Only a POST keeps the advertised body length.
                    if (cur.post_prog != PM_FULL) begin
                        nxt_exp = '0;
                    end else if (cur.header_open) begin
                        nxt_exp = commit_exp;
                    end
                    if (nxt_exp != '0) begin
                        nxt.phase = PH_BODY;
                    end else begin
                        nxt.phase = PH_DONE;
                        verdict   = VERDICT_COMPLETE;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            PH_BODY: begin
                cls      = CLASS_BODY;
                nxt_seen = seen_inc;
                if (seen_inc == cur_exp) begin
                    nxt.phase = PH_DONE;
                    verdict   = VERDICT_COMPLETE;
                end
            end
            PH_DONE: begin
                verdict = VERDICT_COMPLETE;
            end
            default: begin
                nxt.phase = PH_FAIL;
                verdict   = VERDICT_MALFORMED;
            end
        endcase
        if (bad) begin
            nxt.phase = PH_FAIL;
            verdict   = VERDICT_MALFORMED;
            cls       = CLASS_DELIM;
        end
    end

    assign o_ctl       = nxt;
    assign o_len_cand  = nxt_len;
    assign o_exp_body  = nxt_exp;
    assign o_body_seen = nxt_seen;

    assign o_res.verdict    = verdict;
    assign o_res.byte_class = cls;
    assign o_res.header_end = hend;
    assign o_res.is_post    = (nxt.post_prog == PM_FULL);

    assign o_body_length = ((nxt.phase == PH_BODY) || (nxt.phase == PH_DONE)) ?
                           32'(nxt_exp) : 32'd0;

endmodule

### rtl/core/http_request_header_parser_unit.sv
// Top level of the byte-serial HTTP request header parser.
`timescale 1ns / 1ps
// Usage
// The block takes one byte of an HTTP request stream per input transfer
// (i_valid, o_stall, with i_in_byte and i_new_request) and returns exactly
// one result per byte on the output channel (o_valid, i_stall): the verdict,
// a class tag, the byte itself, a header-end pulse, the POST flag, the
// expected body length and the parsed HTTP version.
// Raise i_new_request with the first byte of each request; it returns the
// parser to the method start before that byte is interpreted.
// A byte passes through the input register and then the result register.
// Throughput is one byte per cycle while the receiver does not stall: the parse
// state machine is combinational logic between those two registers.
// When the receiver stalls, the result register holds its transfer and the
// input register can still take one more byte; o_stall rises only once both
// are full. After reset both registers are empty and the parser waits at
// the method start with all counts, versions and lengths at zero.
// Once a request is malformed every later byte reports malformed until a
// new request begins; after completion bytes report complete.
module http_request_header_parser_unit
    import hrhp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_new_request,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_verdict,
    output logic [2:0]  o_byte_class,
    output logic [7:0]  o_out_byte,
    output logic        o_header_end,
    output logic        o_is_post,
    output logic [31:0] o_body_length,
    output logic [7:0]  o_version_major,
    output logic [7:0]  o_version_minor
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_new;

    // Parser state.
    t_ctl                   r_ctl;
    logic [LENGTH_BITS-1:0] r_len_cand;
    logic [LENGTH_BITS-1:0] r_exp_body;
    logic [LENGTH_BITS-1:0] r_body_seen;

    // Result register.
    logic        r_out_valid;
    t_res        r_res;
    logic [7:0]  r_out_byte;
    logic [31:0] r_body_length;
    logic [7:0]  r_major;
    logic [7:0]  r_minor;

    t_ctl                   n_ctl;
    logic [LENGTH_BITS-1:0] n_len_cand;
    logic [LENGTH_BITS-1:0] n_exp_body;
    logic [LENGTH_BITS-1:0] n_body_seen;
    t_res                   n_res;
    logic [31:0]            n_body_length;

    logic out_free;
    logic advance;
    logic in_take;

    // The result register is free when empty or when its transfer completes.
    assign out_free = !r_out_valid || !i_stall;
    // A held byte is parsed in the cycle it can move into the result register.
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    hrhp_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .i_ctl         (r_ctl),
        .i_len_cand    (r_len_cand),
        .i_exp_body    (r_exp_body),
        .i_body_seen   (r_body_seen),
        .i_byte        (r_in_byte),
        .i_new_request (r_in_new),
        .o_ctl         (n_ctl),
        .o_len_cand    (n_len_cand),
        .o_exp_body    (n_exp_body),
        .o_body_seen   (n_body_seen),
        .o_res         (n_res),
        .o_body_length (n_body_length)
    );

    // Control and parser state; the state only moves when a byte is parsed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl       <= CTL_RESET;
            r_len_cand  <= '0;
            r_exp_body  <= '0;
            r_body_seen <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctl       <= n_ctl;
                r_len_cand  <= n_len_cand;
                r_exp_body  <= n_exp_body;
                r_body_seen <= n_body_seen;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset: they are qualified by the valid flags.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
            r_in_new  <= i_new_request;
        end
        if (advance) begin
            r_res         <= n_res;
            r_out_byte    <= r_in_byte;
            r_body_length <= n_body_length;
            r_major       <= n_ctl.major;
            r_minor       <= n_ctl.minor;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_verdict       = r_res.verdict;
    assign o_byte_class    = r_res.byte_class;
    assign o_out_byte      = r_out_byte;
    assign o_header_end    = r_res.header_end;
    assign o_is_post       = r_res.is_post;
    assign o_body_length   = r_body_length;
    assign o_version_major = r_major;
    assign o_version_minor = r_minor;

endmodule

### rtl/core/hrhp_checker.sv
// Port-level assertions for the HTTP request parser, bound to the top level.
`timescale 1ns / 1ps
`include "http_request_header_parser_unit_defines.svh"
module hrhp_checker
    import hrhp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_verdict,
    input logic [2:0]  o_byte_class,
    input logic [7:0]  o_out_byte,
    input logic        o_header_end,
    input logic [31:0] o_body_length
);

    `HRHP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_verdict) && $stable(o_byte_class) && $stable(o_out_byte) && $stable(o_body_length), "stalled result changed")
    `HRHP_ASSERT_IMP(a_bad_delim, i_clk, i_rst_n, o_valid && (o_verdict == VERDICT_MALFORMED), (o_byte_class == CLASS_DELIM) && (o_body_length == 32'd0) && !o_header_end, "malformed result carries class or length")
    `HRHP_ASSERT_IMP(a_body_len, i_clk, i_rst_n, o_valid && (o_byte_class == CLASS_BODY), o_body_length != 32'd0, "body byte with zero body length")
    `HRHP_ASSERT_IMP(a_hend_class, i_clk, i_rst_n, o_valid && o_header_end, (o_byte_class == CLASS_HNAME) || (o_byte_class == CLASS_DELIM), "header end on unexpected class")

endmodule

bind http_request_header_parser_unit hrhp_checker u_hrhp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_verdict     (o_verdict),
    .o_byte_class  (o_byte_class),
    .o_out_byte    (o_out_byte),
    .o_header_end  (o_header_end),
    .o_body_length (o_body_length)
);
